FILE: rtl/stl_pkg.sv
// ----------------------------------------------------------------------------
// stl_pkg
// Shared constants, tables and types for the sRGB to CIELAB converter.
// ----------------------------------------------------------------------------
package stl_pkg;

    localparam int FRAC_BITS = 8;
    localparam int WQ        = 24;
    localparam int SHIFT     = WQ - FRAC_BITS;

    localparam int PIX_W     = 8;
    localparam int L_W       = 15;
    localparam int C_W       = 16;

    localparam int LIN_W     = 25;
    localparam int T_W       = 25;
    localparam int COEF_W    = 24;
    localparam int PROD_W    = COEF_W + LIN_W;
    localparam int NUM_W     = 48;
    localparam int NUM_SH    = 22;
    localparam int A_W       = NUM_W - NUM_SH;
    localparam int RECIP_SH  = 26;
    localparam int QM_W      = A_W + T_W;

    localparam int LT_W      = 18;
    localparam int LN_W      = 32;
    localparam int LN8_W     = LN_W - 3;
    localparam int LF_W      = 22;
    localparam int LQM_W     = 2 * LN8_W;
    localparam int LIN_RSH   = 36;
    localparam int LD_N      = 2 * T_W - 4;

    localparam int SC_W      = 40;

    typedef logic [COEF_W-1:0] coef_row_t [3];

    localparam coef_row_t COEF [3] = '{
        '{24'd4124564, 24'd3575761, 24'd1804375},
        '{24'd2126729, 24'd7151522, 24'd721750},
        '{24'd193339,  24'd1191920, 24'd9503041}
    };

    localparam logic [COEF_W-1:0] DEN [3] = '{24'd9504560, 24'd10000000, 24'd10887540};

    localparam logic [T_W-1:0] RECIP [3] = '{
        T_W'((64'd1 << 48) / 64'd9504560),
        T_W'((64'd1 << 48) / 64'd10000000),
        T_W'((64'd1 << 48) / 64'd10887540)
    };

    localparam logic [T_W-1:0] T_LIM = T_W'((64'd8856 << 24) / 64'd1000000);

    localparam logic [LN_W-1:0]  LIN_K     = 32'd9033;
    localparam logic [LN_W-1:0]  LIN_C     = LN_W'((64'd160 << 24) + 64'd580);
    localparam logic [LN8_W-1:0] LIN_DIV   = 29'd145;
    localparam logic [LN8_W-1:0] LIN_RECIP = LN8_W'((64'd1 << 36) / 64'd145);

    localparam int LMAX_I = ((100 << FRAC_BITS) > 32767) ? 32767 : (100 << FRAC_BITS);
    localparam logic signed [SC_W-1:0] LMAX   = SC_W'(LMAX_I);
    localparam logic signed [SC_W-1:0] CMAX   = 40'sd32767;
    localparam logic signed [SC_W-1:0] CMIN   = -40'sd32768;
    localparam logic signed [SC_W-1:0] HALF   = 40'sd1 <<< (SHIFT - 1);
    localparam logic signed [SC_W-1:0] L_OFS  = 40'sd16 <<< WQ;

    typedef logic [LIN_W-1:0] lin_tab_t [256];

    function automatic logic [63:0] pow5_q30(input logic [63:0] y);
        logic [63:0] y2;
        logic [63:0] y4;
        y2 = (y * y) >> 30;
        y4 = (y2 * y2) >> 30;
        return (y4 * y) >> 30;
    endfunction

    function automatic logic [LIN_W-1:0] lin_of(input logic [63:0] c);
        logic [63:0] x;
        logic [63:0] s;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        if (c * 64'd100000 <= 64'd1031475)
        begin
            return LIN_W'((c * 64'd100 * (64'd1 << 24) + 64'd164730) / 64'd329460);
        end
        x  = (((64'd1000 * c + 64'd14025) << 30) + 64'd134512) / 64'd269025;
        s  = (x * x + (64'd1 << 29)) >> 30;
        lo = 64'd0;
        hi = 64'd1 << 30;
        for (int i = 0; i < 32; i++)
        begin
            if (lo < hi)
            begin
                mid = (lo + hi + 64'd1) >> 1;
                if (pow5_q30(mid) <= s)
                begin
                    lo = mid;
                end
                else
                begin
                    hi = mid - 64'd1;
                end
            end
        end
        return LIN_W'((s * lo + (64'd1 << 35)) >> 36);
    endfunction

    function automatic lin_tab_t build_lin();
        lin_tab_t tab;
        for (int c = 0; c < 256; c++)
        begin
            tab[c] = lin_of(64'(c));
        end
        return tab;
    endfunction

    localparam lin_tab_t LIN_TAB = build_lin();

endpackage

FILE: rtl/stl_rgb_if.sv
// ----------------------------------------------------------------------------
// stl_rgb_if
// Pixel channel: valid/ready handshake with an 8-bit sRGB payload.
// ----------------------------------------------------------------------------
interface stl_rgb_if;
    logic                       valid;
    logic                       ready;
    logic [stl_pkg::PIX_W-1:0]  red;
    logic [stl_pkg::PIX_W-1:0]  green;
    logic [stl_pkg::PIX_W-1:0]  blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

FILE: rtl/stl_lab_if.sv
// ----------------------------------------------------------------------------
// stl_lab_if
// Result channel: valid/ready handshake with a fixed-point CIELAB payload.
// ----------------------------------------------------------------------------
interface stl_lab_if;
    logic                              valid;
    logic                              ready;
    logic        [stl_pkg::L_W-1:0]    lightness;
    logic signed [stl_pkg::C_W-1:0]    chroma_a;
    logic signed [stl_pkg::C_W-1:0]    chroma_b;

    modport source (output valid, lightness, chroma_a, chroma_b, input ready);
    modport sink   (input valid, lightness, chroma_a, chroma_b, output ready);
endinterface

FILE: rtl/stl_ratio.sv
// ----------------------------------------------------------------------------
// stl_ratio
// Linearizes the pixel, applies the XYZ matrix and divides by the white point.
// Six register stages.
// ----------------------------------------------------------------------------
module stl_ratio
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [stl_pkg::PIX_W-1:0]    red,
    input  logic [stl_pkg::PIX_W-1:0]    green,
    input  logic [stl_pkg::PIX_W-1:0]    blue,
    output logic                         out_valid,
    output logic [stl_pkg::T_W-1:0]      tx,
    output logic [stl_pkg::T_W-1:0]      ty,
    output logic [stl_pkg::T_W-1:0]      tz
);

    logic [5:0]                       v_reg;
    logic [stl_pkg::LIN_W-1:0]        lin_reg  [3];
    logic [stl_pkg::PROD_W-1:0]       prod_reg [3][3];
    logic [stl_pkg::NUM_W-1:0]        num_reg  [3];
    logic [stl_pkg::NUM_W-1:0]        num4_reg [3];
    logic [stl_pkg::NUM_W-1:0]        num5_reg [3];
    logic [stl_pkg::T_W-1:0]          q4_reg   [3];
    logic [stl_pkg::T_W-1:0]          q5_reg   [3];
    logic [stl_pkg::NUM_W-1:0]        p_reg    [3];
    logic [stl_pkg::T_W-1:0]          t_reg    [3];
    logic [stl_pkg::NUM_W-1:0]        rem_next [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[4:0], in_valid};
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            rem_next[k] = num5_reg[k] - p_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lin_reg[0] <= stl_pkg::LIN_TAB[red];
            lin_reg[1] <= stl_pkg::LIN_TAB[green];
            lin_reg[2] <= stl_pkg::LIN_TAB[blue];
            for (int k = 0; k < 3; k++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    prod_reg[k][j] <= stl_pkg::PROD_W'(stl_pkg::COEF[k][j])
                                    * stl_pkg::PROD_W'(lin_reg[j]);
                end
                num_reg[k]  <= stl_pkg::NUM_W'(prod_reg[k][0] + prod_reg[k][1]
                               + prod_reg[k][2]
                               + stl_pkg::PROD_W'(stl_pkg::DEN[k] >> 1));
                q4_reg[k]   <= stl_pkg::T_W'((stl_pkg::QM_W'(num_reg[k][stl_pkg::NUM_W-1:
                               stl_pkg::NUM_SH]) * stl_pkg::QM_W'(stl_pkg::RECIP[k]))
                               >> stl_pkg::RECIP_SH);
                num4_reg[k] <= num_reg[k];
                p_reg[k]    <= stl_pkg::NUM_W'(stl_pkg::PROD_W'(q4_reg[k])
                               * stl_pkg::PROD_W'(stl_pkg::DEN[k]));
                q5_reg[k]   <= q4_reg[k];
                num5_reg[k] <= num4_reg[k];
                t_reg[k]    <= q5_reg[k]
                    + stl_pkg::T_W'(rem_next[k] >= stl_pkg::NUM_W'(stl_pkg::DEN[k]))
                    + stl_pkg::T_W'(rem_next[k] >= (stl_pkg::NUM_W'(stl_pkg::DEN[k]) << 1));
            end
        end
    end

    assign out_valid = v_reg[5];
    assign tx        = t_reg[0];
    assign ty        = t_reg[1];
    assign tz        = t_reg[2];

endmodule

FILE: rtl/stl_curve.sv
// ----------------------------------------------------------------------------
// stl_curve
// CIELAB companding curve for one channel: bit-by-bit cube root, two stages
// per result bit, with the linear segment computed alongside.
// ----------------------------------------------------------------------------
module stl_curve
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [stl_pkg::T_W-1:0]   t,
    output logic                      out_valid,
    output logic [stl_pkg::T_W-1:0]   f
);

    logic [2*stl_pkg::T_W:0]          v_reg;
    logic [stl_pkg::T_W-1:0]          y_in     [stl_pkg::T_W];
    logic [stl_pkg::T_W-1:0]          t_in     [stl_pkg::T_W];
    logic [stl_pkg::T_W-1:0]          cand_reg [stl_pkg::T_W];
    logic [stl_pkg::T_W:0]            sq_reg   [stl_pkg::T_W];
    logic [stl_pkg::T_W-1:0]          ta_reg   [stl_pkg::T_W];
    logic [stl_pkg::T_W-1:0]          tb_reg   [stl_pkg::T_W];
    logic [stl_pkg::T_W-1:0]          y_reg    [stl_pkg::T_W];
    logic [stl_pkg::T_W-1:0]          cand_next[stl_pkg::T_W];
    logic [stl_pkg::T_W+1:0]          cube_next[stl_pkg::T_W];

    logic [stl_pkg::LN_W-1:0]         ln_reg;
    logic [stl_pkg::LN8_W-1:0]        ln2_reg;
    logic [stl_pkg::LN8_W-1:0]        ln3_reg;
    logic [stl_pkg::LF_W-1:0]         lq_reg;
    logic [stl_pkg::LF_W-1:0]         lq3_reg;
    logic [stl_pkg::LN8_W-1:0]        lp_reg;
    logic [stl_pkg::LF_W-1:0]         lf_reg;
    logic [stl_pkg::LF_W-1:0]         ld_reg   [stl_pkg::LD_N];
    logic [stl_pkg::T_W-1:0]          f_reg;

    assign y_in[0] = '0;
    assign t_in[0] = t;

    generate
        for (genvar j = 1; j < stl_pkg::T_W; j++)
        begin : g_link
            assign y_in[j] = y_reg[j-1];
            assign t_in[j] = tb_reg[j-1];
        end
    endgenerate

    always_comb
    begin
        for (int j = 0; j < stl_pkg::T_W; j++)
        begin
            cand_next[j] = y_in[j] | (stl_pkg::T_W'(1) << (stl_pkg::T_W - 1 - j));
            cube_next[j] = (stl_pkg::T_W+2)'(((2*stl_pkg::T_W+1)'(sq_reg[j])
                           * (2*stl_pkg::T_W+1)'(cand_reg[j])) >> stl_pkg::WQ);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[2*stl_pkg::T_W-1:0], in_valid};
        end
    end

    // cube root search, one result bit per stage pair
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < stl_pkg::T_W; j++)
            begin
                cand_reg[j] <= cand_next[j];
                sq_reg[j]   <= (stl_pkg::T_W+1)'(((2*stl_pkg::T_W)'(cand_next[j])
                               * (2*stl_pkg::T_W)'(cand_next[j])) >> stl_pkg::WQ);
                ta_reg[j]   <= t_in[j];
                tb_reg[j]   <= ta_reg[j];
                if (cube_next[j] <= (stl_pkg::T_W+2)'(ta_reg[j]))
                begin
                    y_reg[j] <= cand_reg[j];
                end
                else
                begin
                    y_reg[j] <= cand_reg[j]
                              & ~(stl_pkg::T_W'(1) << (stl_pkg::T_W - 1 - j));
                end
            end
        end
    end

    // linear segment, divide by 1160 as shift by 3 then reciprocal of 145
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ln_reg  <= stl_pkg::LN_W'(stl_pkg::LN_W'(t[stl_pkg::LT_W-1:0]) * stl_pkg::LIN_K)
                       + stl_pkg::LIN_C;
            lq_reg  <= stl_pkg::LF_W'((stl_pkg::LQM_W'(ln_reg[stl_pkg::LN_W-1:3])
                       * stl_pkg::LQM_W'(stl_pkg::LIN_RECIP)) >> stl_pkg::LIN_RSH);
            ln2_reg <= ln_reg[stl_pkg::LN_W-1:3];
            lp_reg  <= stl_pkg::LN8_W'(stl_pkg::LN8_W'(lq_reg) * stl_pkg::LIN_DIV);
            lq3_reg <= lq_reg;
            ln3_reg <= ln2_reg;
            lf_reg  <= lq3_reg + stl_pkg::LF_W'((ln3_reg - lp_reg) >= stl_pkg::LIN_DIV);
            ld_reg[0] <= lf_reg;
            for (int i = 1; i < stl_pkg::LD_N; i++)
            begin
                ld_reg[i] <= ld_reg[i-1];
            end
            if (tb_reg[stl_pkg::T_W-1] > stl_pkg::T_LIM)
            begin
                f_reg <= y_reg[stl_pkg::T_W-1];
            end
            else
            begin
                f_reg <= stl_pkg::T_W'(ld_reg[stl_pkg::LD_N-1]);
            end
        end
    end

    assign out_valid = v_reg[2*stl_pkg::T_W];
    assign f         = f_reg;

endmodule

FILE: rtl/srgb_to_lab_converter_unit.sv
// ----------------------------------------------------------------------------
// srgb_to_lab_converter_unit
// sRGB pixel to CIELAB (D65) in fixed point with signed a and b, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while the output is not stalled and returns one
// result per pixel, in order. The depth is set by the cube root of the
// companding curve, which resolves one result bit per two stages over 25 bits
// and then spends one stage choosing between the root and the linear segment;
// six stages before it build the white-point ratios and two after it scale,
// round and saturate. The whole pipeline holds while a result waits at the
// output, so nothing is dropped or repeated under backpressure.
module srgb_to_lab_converter_unit
(
    input  logic        clk,
    input  logic        rst_n,
    stl_rgb_if.sink     pixel,
    stl_lab_if.source   lab
);

    logic                             en;
    logic                             rv;
    logic                             vx;
    logic                             vy;
    logic                             vz;
    logic [stl_pkg::T_W-1:0]          tx;
    logic [stl_pkg::T_W-1:0]          ty;
    logic [stl_pkg::T_W-1:0]          tz;
    logic [stl_pkg::T_W-1:0]          fx;
    logic [stl_pkg::T_W-1:0]          fy;
    logic [stl_pkg::T_W-1:0]          fz;

    logic [1:0]                       vo_reg;
    logic signed [stl_pkg::SC_W-1:0]  ls_reg;
    logic signed [stl_pkg::SC_W-1:0]  as_reg;
    logic signed [stl_pkg::SC_W-1:0]  bs_reg;
    logic signed [stl_pkg::SC_W-1:0]  lr_next;
    logic signed [stl_pkg::SC_W-1:0]  ar_next;
    logic signed [stl_pkg::SC_W-1:0]  br_next;
    logic [stl_pkg::L_W-1:0]          l_next;
    logic signed [stl_pkg::C_W-1:0]   a_next;
    logic signed [stl_pkg::C_W-1:0]   b_next;
    logic [stl_pkg::L_W-1:0]          l_reg;
    logic signed [stl_pkg::C_W-1:0]   a_reg;
    logic signed [stl_pkg::C_W-1:0]   b_reg;

    assign en          = !vo_reg[1] || lab.ready;
    assign pixel.ready = en;

    stl_ratio u_ratio
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pixel.valid),
        .red       (pixel.red),
        .green     (pixel.green),
        .blue      (pixel.blue),
        .out_valid (rv),
        .tx        (tx),
        .ty        (ty),
        .tz        (tz)
    );

    stl_curve u_curve_x
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (rv),
        .t         (tx),
        .out_valid (vx),
        .f         (fx)
    );

    stl_curve u_curve_y
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (rv),
        .t         (ty),
        .out_valid (vy),
        .f         (fy)
    );

    stl_curve u_curve_z
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (rv),
        .t         (tz),
        .out_valid (vz),
        .f         (fz)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vo_reg <= '0;
        end
        else if (en)
        begin
            vo_reg <= {vo_reg[0], vx && vy && vz};
        end
    end

    // rounding half up, then saturation
    always_comb
    begin
        lr_next = (ls_reg + stl_pkg::HALF) >>> stl_pkg::SHIFT;
        ar_next = (as_reg + stl_pkg::HALF) >>> stl_pkg::SHIFT;
        br_next = (bs_reg + stl_pkg::HALF) >>> stl_pkg::SHIFT;
        priority if (lr_next < 0)
        begin
            l_next = '0;
        end
        else if (lr_next > stl_pkg::LMAX)
        begin
            l_next = stl_pkg::L_W'(stl_pkg::LMAX);
        end
        else
        begin
            l_next = lr_next[stl_pkg::L_W-1:0];
        end
        priority if (ar_next < stl_pkg::CMIN)
        begin
            a_next = stl_pkg::C_W'(stl_pkg::CMIN);
        end
        else if (ar_next > stl_pkg::CMAX)
        begin
            a_next = stl_pkg::C_W'(stl_pkg::CMAX);
        end
        else
        begin
            a_next = ar_next[stl_pkg::C_W-1:0];
        end
        priority if (br_next < stl_pkg::CMIN)
        begin
            b_next = stl_pkg::C_W'(stl_pkg::CMIN);
        end
        else if (br_next > stl_pkg::CMAX)
        begin
            b_next = stl_pkg::C_W'(stl_pkg::CMAX);
        end
        else
        begin
            b_next = br_next[stl_pkg::C_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ls_reg <= 40'sd116 * $signed({15'd0, fy}) - stl_pkg::L_OFS;
            as_reg <= 40'sd500 * ($signed({15'd0, fx}) - $signed({15'd0, fy}));
            bs_reg <= 40'sd200 * ($signed({15'd0, fy}) - $signed({15'd0, fz}));
            l_reg  <= l_next;
            a_reg  <= a_next;
            b_reg  <= b_next;
        end
    end

    assign lab.valid     = vo_reg[1];
    assign lab.lightness = l_reg;
    assign lab.chroma_a  = a_reg;
    assign lab.chroma_b  = b_reg;

endmodule
